/* rtl/particle_plane_collision_defines.svh */
// Assertion macros for the particle/plane collision block.
// Included by the top level; expands to nothing in synthesis.
`ifndef PARTICLE_PLANE_COLLISION_DEFINES_SVH
`define PARTICLE_PLANE_COLLISION_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property outside reset.
`define PPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: label");
// Check a property at every edge, reset included.
`define PPC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");
`else
`define PPC_ASSERT(label, clk, rst_n, prop)
`define PPC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* rtl/ppc_pkg.sv */
// Shared types, register indexes and helpers for the particle/plane block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FLOOR       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STICKING_MODE = 3'd5;

    // Reset values
    localparam logic signed [17:0] NORMAL_X_RST = 18'sd0;
    localparam logic signed [17:0] NORMAL_Y_RST = 18'sd65536;
    localparam logic signed [31:0] Y_FLOOR_RST  = 32'sh8000_0000;

    typedef struct packed {
        logic signed [17:0] normal_x;
        logic signed [17:0] normal_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] y_floor;
        logic               sticking_mode;
    } t_ppc_cfg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               last;
    } t_ppc_item;

    // Stage load enables, one per register stage
    typedef struct packed {
        logic en_s1;
        logic en_s2;
        logic en_s3;
        logic en_s4;
        logic en_s5;
    } t_ppc_ctl;

    // Distance stage results handed to the response stages
    typedef struct packed {
        t_ppc_item          item;
        logic               skip;
        logic               d_le;
        logic               vn_le;
        logic signed [35:0] d;
        logic signed [34:0] vn;
    } t_ppc_dist;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               contact;
        logic               last_out;
    } t_ppc_out;

    // Clamp a 40-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if ((&x[39:31]) || (~|x[39:31])) begin
            r = x[31:0];
        end else if (x[39]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ppc_dist.sv */
// Stages 1-3: plane offset and skip test, normal products, rounded distance
// and normal velocity. Depends on ppc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppc_dist (
    input  wire logic              i_clk,
    input  ppc_pkg::t_ppc_ctl      i_ctl,
    input  ppc_pkg::t_ppc_cfg      i_cfg,
    input  ppc_pkg::t_ppc_item     i_item,
    output ppc_pkg::t_ppc_dist     o_dist
);
    import ppc_pkg::*;

    // Stage 1 registers
    t_ppc_item          r1_item;
    logic               r1_skip;
    logic signed [32:0] r1_dx;
    logic signed [32:0] r1_dy;
    logic signed [32:0] n_dx;
    logic signed [32:0] n_dy;

    // Stage 2 registers
    t_ppc_item          r2_item;
    logic               r2_skip;
    logic signed [50:0] r2_pdx;
    logic signed [50:0] r2_pdy;
    logic signed [49:0] r2_pvx;
    logic signed [49:0] r2_pvy;

    // Stage 3 sums
    logic signed [51:0] n_draw;
    logic signed [51:0] n_draw_rnd;
    logic signed [50:0] n_vnraw;
    logic signed [50:0] n_vn_rnd;

    t_ppc_dist r3_dist;

    // Offset from the plane point
    assign n_dx = 33'(i_item.pos_x) - 33'(i_cfg.point_x);
    assign n_dy = 33'(i_item.pos_y) - 33'(i_cfg.point_y);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            r1_item <= i_item;
            r1_skip <= (i_item.pos_y < i_cfg.y_floor);
            r1_dx   <= n_dx;
            r1_dy   <= n_dy;
        end
    end

    // Project offset and velocity on the normal
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r2_item <= r1_item;
            r2_skip <= r1_skip;
            r2_pdx  <= 51'(i_cfg.normal_x) * 51'(r1_dx);
            r2_pdy  <= 51'(i_cfg.normal_y) * 51'(r1_dy);
            r2_pvx  <= 50'(i_cfg.normal_x) * 50'(r1_item.vel_x);
            r2_pvy  <= 50'(i_cfg.normal_y) * 50'(r1_item.vel_y);
        end
    end

    // Sum, test sign on the exact value, round half up to Q20.16 (distance) and Q19.16 (normal velocity)
    assign n_draw     = 52'(r2_pdx) + 52'(r2_pdy);
    assign n_draw_rnd = n_draw + 52'sd32768;
    assign n_vnraw    = 51'(r2_pvx) + 51'(r2_pvy);
    assign n_vn_rnd   = n_vnraw + 51'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s3) begin
            r3_dist.item  <= r2_item;
            r3_dist.skip  <= r2_skip;
            r3_dist.d_le  <= n_draw[51] || (n_draw == '0);
            r3_dist.vn_le <= n_vnraw[50] || (n_vnraw == '0);
            r3_dist.d     <= n_draw_rnd[51:16];
            r3_dist.vn    <= n_vn_rnd[50:16];
        end
    end

    assign o_dist = r3_dist;

endmodule

`default_nettype wire

/* rtl/ppc_resp.sv */
// Stages 4-5: push-out and velocity correction products, rounding,
// saturation and result selection. Depends on ppc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppc_resp (
    input  wire logic              i_clk,
    input  ppc_pkg::t_ppc_ctl      i_ctl,
    input  ppc_pkg::t_ppc_cfg      i_cfg,
    input  ppc_pkg::t_ppc_dist     i_dist,
    output ppc_pkg::t_ppc_out      o_res
);
    import ppc_pkg::*;

    // Stage 4 registers
    t_ppc_item          r4_item;
    logic               r4_skip;
    logic               r4_d_le;
    logic               r4_vn_le;
    logic signed [54:0] r4_pnx;
    logic signed [54:0] r4_pny;
    logic signed [52:0] r4_qvx;
    logic signed [52:0] r4_qvy;
    logic signed [36:0] n_neg_d;

    // Stage 5 logic
    logic signed [54:0] n_pnx_rnd;
    logic signed [54:0] n_pny_rnd;
    logic signed [52:0] n_qvx_rnd;
    logic signed [52:0] n_qvy_rnd;
    logic signed [38:0] n_push_x;
    logic signed [38:0] n_push_y;
    logic signed [36:0] n_corr_x;
    logic signed [36:0] n_corr_y;
    logic signed [37:0] n_vsub_x;
    logic signed [37:0] n_vsub_y;
    logic               n_contact;
    t_ppc_out           n_res;
    t_ppc_out           r5_res;

    assign n_neg_d = 37'sd0 - 37'(i_dist.d);

    // Scale distance and normal velocity back onto the normal
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s4) begin
            r4_item  <= i_dist.item;
            r4_skip  <= i_dist.skip;
            r4_d_le  <= i_dist.d_le;
            r4_vn_le <= i_dist.vn_le;
            r4_pnx   <= 55'(n_neg_d) * 55'(i_cfg.normal_x);
            r4_pny   <= 55'(n_neg_d) * 55'(i_cfg.normal_y);
            r4_qvx   <= 53'(i_dist.vn) * 53'(i_cfg.normal_x);
            r4_qvy   <= 53'(i_dist.vn) * 53'(i_cfg.normal_y);
        end
    end

    // Round push-out to Q23.16 and velocity correction to Q21.16 and apply the corrections
    assign n_pnx_rnd = r4_pnx + 55'sd32768;
    assign n_pny_rnd = r4_pny + 55'sd32768;
    assign n_qvx_rnd = r4_qvx + 53'sd32768;
    assign n_qvy_rnd = r4_qvy + 53'sd32768;
    assign n_push_x  = n_pnx_rnd[54:16];
    assign n_push_y  = n_pny_rnd[54:16];
    assign n_corr_x  = n_qvx_rnd[52:16];
    assign n_corr_y  = n_qvy_rnd[52:16];
    assign n_vsub_x  = 38'(r4_item.vel_x) - 38'(n_corr_x);
    assign n_vsub_y  = 38'(r4_item.vel_y) - 38'(n_corr_y);
    assign n_contact = !r4_skip && r4_d_le;

    // Pick corrected or pass-through values
    always_comb begin
        n_res.new_pos_x = r4_item.pos_x;
        n_res.new_pos_y = r4_item.pos_y;
        n_res.new_vel_x = r4_item.vel_x;
        n_res.new_vel_y = r4_item.vel_y;
        n_res.contact   = n_contact;
        n_res.last_out  = r4_item.last;
        if (n_contact) begin
            n_res.new_pos_x = sat32(40'(r4_item.pos_x) + 40'(n_push_x));
            n_res.new_pos_y = sat32(40'(r4_item.pos_y) + 40'(n_push_y));
            if (i_cfg.sticking_mode) begin
                n_res.new_vel_x = '0;
                n_res.new_vel_y = '0;
            end else if (r4_vn_le) begin
                n_res.new_vel_x = sat32(40'(n_vsub_x));
                n_res.new_vel_y = sat32(40'(n_vsub_y));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s5) begin
            r5_res <= n_res;
        end
    end

    assign o_res = r5_res;

endmodule

`default_nettype wire

/* rtl/particle_plane_collision.sv */
// Top level of the particle/plane collision block: configuration registers,
// stage valid tracking and handshakes. Depends on ppc_pkg, ppc_dist, ppc_resp.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_plane_collision_defines.svh"

// Resolves one 2D particle against one static plane per beat. The datapath is
// a five-stage pipeline (offset, normal products, rounded distance, push-out
// products, round/saturate into the output register), so one particle can be
// accepted every cycle while the result side does not stall.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up and input is still taken while a result waits at the
// output, until all five stages hold a particle. Configuration writes are
// taken in any cycle (o_cfg_ready is always high) but must only be issued
// while no particle is in flight.
module particle_plane_collision (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ppc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ppc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // particle input channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [31:0]              i_pos_x,
    input  wire logic signed [31:0]              i_pos_y,
    input  wire logic signed [31:0]              i_vel_x,
    input  wire logic signed [31:0]              i_vel_y,
    input  wire logic                            i_last_point,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [31:0]                   o_new_pos_x,
    output logic signed [31:0]                   o_new_pos_y,
    output logic signed [31:0]                   o_new_vel_x,
    output logic signed [31:0]                   o_new_vel_y,
    output logic                                 o_contact,
    output logic                                 o_last_out
);
    import ppc_pkg::*;

    localparam int NUM_STAGES = 5;

    t_ppc_cfg                r_cfg;
    logic [NUM_STAGES-1:0]   r_v;
    logic [NUM_STAGES-1:0]   n_v;
    logic [NUM_STAGES-1:0]   adv;
    t_ppc_ctl                ctl;
    t_ppc_item               in_item;
    t_ppc_dist               dist_bus;
    t_ppc_out                res;
    logic                    stick_out;

    // Configuration registers; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x      <= NORMAL_X_RST;
            r_cfg.normal_y      <= NORMAL_Y_RST;
            r_cfg.point_x       <= '0;
            r_cfg.point_y       <= '0;
            r_cfg.y_floor       <= Y_FLOOR_RST;
            r_cfg.sticking_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NORMAL_X:      r_cfg.normal_x      <= i_cfg_data[17:0];
                REG_NORMAL_Y:      r_cfg.normal_y      <= i_cfg_data[17:0];
                REG_POINT_X:       r_cfg.point_x       <= i_cfg_data;
                REG_POINT_Y:       r_cfg.point_y       <= i_cfg_data;
                REG_Y_FLOOR:       r_cfg.y_floor       <= i_cfg_data;
                REG_STICKING_MODE: r_cfg.sticking_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when empty or when its successor moves
    always_comb begin
        adv[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
        n_v[0] = adv[0] ? i_valid : r_v[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_v[k] = adv[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign ctl.en_s1 = adv[0];
    assign ctl.en_s2 = adv[1];
    assign ctl.en_s3 = adv[2];
    assign ctl.en_s4 = adv[3];
    assign ctl.en_s5 = adv[4];

    assign o_ready = adv[0];
    assign o_valid = r_v[NUM_STAGES-1];

    assign in_item.pos_x = i_pos_x;
    assign in_item.pos_y = i_pos_y;
    assign in_item.vel_x = i_vel_x;
    assign in_item.vel_y = i_vel_y;
    assign in_item.last  = i_last_point;

    ppc_dist u_dist (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_item (in_item),
        .o_dist (dist_bus)
    );

    ppc_resp u_resp (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_dist (dist_bus),
        .o_res  (res)
    );

    assign o_new_pos_x = res.new_pos_x;
    assign o_new_pos_y = res.new_pos_y;
    assign o_new_vel_x = res.new_vel_x;
    assign o_new_vel_y = res.new_vel_y;
    assign o_contact   = res.contact;
    assign o_last_out  = res.last_out;

    assign stick_out = o_valid && o_contact && r_cfg.sticking_mode;

    // Input is refused only when every stage holds a particle
    `PPC_ASSERT(a_full_when_stalled, i_clk, i_rst_n, !o_ready |-> (&r_v))
    // Reset empties the pipeline
    `PPC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (r_v == '0))
    // Sticking contact leaves the particle at rest
    `PPC_ASSERT(a_stick_zero_vel, i_clk, i_rst_n, stick_out |-> ~|(o_new_vel_x | o_new_vel_y))

endmodule

`default_nettype wire
